// ----- design/fdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and helper functions for the fog density curve
// generator.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int unsigned TABLE_LEN = 32;
  localparam int unsigned IDX_W     = $clog2(TABLE_LEN);
  localparam int unsigned DENS_W    = 7;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned OFFS_W    = 15;
  localparam int unsigned COLOR_W   = 15;
  localparam int unsigned ALPHA_W   = 5;
  localparam int unsigned WORD_W    = 21;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned TDATA_W   = 56;
  localparam int unsigned FRAC_W    = 12;

  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(TABLE_LEN - 1);
  localparam logic [OFFS_W-1:0]  DEPTH_MAX   = 15'h7FFF;
  localparam logic [DENS_W-1:0]  DENS_MAX    = 7'd127;
  localparam logic [12:0]        LIN_GAIN    = 13'd4196;
  localparam logic [12:0]        SQ_GAIN     = 13'd4331;
  localparam logic [7:0]         SMOOTH_STEP = 8'd132;
  localparam logic [7:0]         EXP_BIAS    = 8'd7;
  localparam logic [SHIFT_W-1:0] SHIFT_TOP   = 4'd10;

  typedef enum logic [KIND_W-1:0] {
    CURVE_LINEAR  = 2'd0,
    CURVE_SQUARED = 2'd1,
    CURVE_EXP     = 2'd2,
    CURVE_SMOOTH  = 2'd3
  } curve_t;

  // Per-entry side information that travels with each table entry.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               rej;
    logic               last;
    logic [SHIFT_W-1:0] shift;
    logic [OFFS_W-1:0]  offs;
    logic [WORD_W-1:0]  word;
  } meta_t;

  // Largest shift in 1..10 whose span covers the depth range, else 0.
  // The compares are independent; the highest passing one wins.
  function automatic logic [SHIFT_W-1:0] pick_shift(input logic [OFFS_W-1:0] span);
    logic [SHIFT_W-1:0] sh;
    sh = '0;
    for (int k = 1; k <= 10; k++) begin
      if ((16'h8000 >> k) >= {1'b0, span}) begin
        sh = SHIFT_W'(k);
      end
    end
    if (span == '0) begin
      sh = SHIFT_TOP;
    end
    return sh;
  endfunction

endpackage

// ----- design/fdc_seq.sv -----
// ----------------------------------------------------------------------------
// fdc_seq
// Request register and entry sequencer. Holds one setup request and issues
// its table entries one per advancing cycle, with the exponential curve
// carried as a running value.
// ----------------------------------------------------------------------------
module fdc_seq
  import fdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [KIND_W-1:0]   req_kind,
  input  logic [DEPTH_W-1:0]  req_near,
  input  logic [DEPTH_W-1:0]  req_far,
  input  logic [COLOR_W-1:0]  req_color,
  input  logic [ALPHA_W-1:0]  req_alpha,
  output logic                ent_valid,
  output logic [KIND_W-1:0]   ent_kind,
  output logic [DENS_W-1:0]   ent_expd,
  output meta_t               ent_meta
);

  logic                busy;
  logic [IDX_W-1:0]    cnt;
  logic [DENS_W-1:0]   expd;
  logic                rej;
  logic [KIND_W-1:0]   kind;
  logic [OFFS_W-1:0]   span;
  logic [OFFS_W-1:0]  offs;
  logic [WORD_W-1:0]   word;

  logic                seq_last;
  logic                accept;
  logic [OFFS_W-1:0]   near_c;
  logic [OFFS_W-1:0]   far_c;
  logic [4:0]          exp_step;

  assign seq_last  = rej || (cnt == LAST_IDX);
  assign req_ready = adv && (!busy || seq_last);
  assign accept    = req_valid && req_ready;

  assign near_c = (req_near > {1'b0, DEPTH_MAX}) ? DEPTH_MAX : req_near[OFFS_W-1:0];
  assign far_c  = (req_far  > {1'b0, DEPTH_MAX}) ? DEPTH_MAX : req_far[OFFS_W-1:0];

  // One step of the exponential approach toward full density.
  assign exp_step = 5'(({1'b0, DENS_MAX} - {1'b0, expd} + EXP_BIAS) >> 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ent_valid <= 1'b0;
    end else if (adv) begin
      ent_valid <= busy;
      if (busy) begin
        ent_kind       <= kind;
        ent_expd       <= expd;
        ent_meta.idx   <= rej ? '0 : cnt;
        ent_meta.rej   <= rej;
        ent_meta.last  <= seq_last;
        ent_meta.shift <= rej ? '0 : pick_shift(span);
        ent_meta.offs  <= rej ? '0 : offs;
        ent_meta.word  <= rej ? '0 : word;
        cnt            <= cnt + 1'b1;
        expd           <= expd + DENS_W'(exp_step);
        if (seq_last) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        busy  <= 1'b1;
        cnt   <= '0;
        expd  <= '0;
        rej   <= (req_far <= req_near);
        kind  <= req_kind;
        span  <= far_c - near_c;
        offs  <= near_c;
        word  <= {req_alpha, 1'b0, req_color};
      end
    end
  end

endmodule

// ----- design/fdc_curve.sv -----
// ----------------------------------------------------------------------------
// fdc_curve
// Four-stage density pipeline: index products, squares, cube term, then the
// smoothstep scale and the curve select into the output register.
// ----------------------------------------------------------------------------
module fdc_curve
  import fdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [DENS_W-1:0]   in_expd,
  input  meta_t               in_meta,
  output logic                out_valid,
  output logic [DENS_W-1:0]   out_dens,
  output meta_t               out_meta
);

  // Stage 2
  logic                v2;
  logic [KIND_W-1:0]   kind2;
  logic [DENS_W-1:0]   expd2;
  meta_t               meta2;
  logic [DENS_W-1:0]   lin2;
  logic [9:0]          sqp2;
  logic [FRAC_W-1:0]   t2r;
  // Stage 3
  logic                v3;
  logic [KIND_W-1:0]   kind3;
  logic [DENS_W-1:0]   expd3;
  meta_t               meta3;
  logic [DENS_W-1:0]   lin3;
  logic [DENS_W-1:0]   sq3;
  logic [FRAC_W-1:0]   t3r;
  logic [FRAC_W-1:0]   tt3;
  // Stage 4
  logic                v4;
  logic [KIND_W-1:0]   kind4;
  logic [DENS_W-1:0]   expd4;
  meta_t               meta4;
  logic [DENS_W-1:0]   lin4;
  logic [DENS_W-1:0]   sq4;
  logic [FRAC_W-1:0]   tt4;
  logic [FRAC_W-1:0]   ttt4;

  logic [17:0]         lin_prod;
  logic [22:0]         sq_prod;
  logic [23:0]         tt_prod;
  logic [23:0]         ttt_prod;
  logic [13:0]         s_pos;
  logic [12:0]         s_neg;
  logic [13:0]         s_val;
  logic [20:0]         sm_prod;
  logic [DENS_W-1:0]   smooth;
  logic [DENS_W-1:0]   dens;

  assign lin_prod = 18'(in_meta.idx) * 18'(LIN_GAIN);
  assign sq_prod  = 23'(sqp2) * 23'(SQ_GAIN);
  assign tt_prod  = 24'(t2r) * 24'(t2r);
  assign ttt_prod = 24'(tt3) * 24'(t3r);

  // Smoothstep 3t^2 - 2t^3, floored at zero.
  assign s_pos   = 14'(tt4) + 14'({tt4, 1'b0});
  assign s_neg   = {ttt4, 1'b0};
  assign s_val   = (s_pos > 14'(s_neg)) ? (s_pos - 14'(s_neg)) : '0;
  assign sm_prod = 21'(s_val) * 21'(DENS_MAX);
  assign smooth  = sm_prod[FRAC_W +: DENS_W];

  always_comb begin
    case (curve_t'(kind4))
      CURVE_SQUARED: dens = sq4;
      CURVE_EXP:     dens = expd4;
      CURVE_SMOOTH:  dens = smooth;
      default:       dens = lin4;
    endcase
    if (meta4.rej) begin
      dens = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v2        <= in_valid;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2    <= in_kind;
      expd2    <= in_expd;
      meta2    <= in_meta;
      lin2     <= lin_prod[10 +: DENS_W];
      sqp2     <= 10'(in_meta.idx) * 10'(in_meta.idx);
      t2r      <= FRAC_W'(in_meta.idx) * FRAC_W'(SMOOTH_STEP);

      kind3    <= kind2;
      expd3    <= expd2;
      meta3    <= meta2;
      lin3     <= lin2;
      sq3      <= sq_prod[15 +: DENS_W];
      t3r      <= t2r;
      tt3      <= tt_prod[FRAC_W +: FRAC_W];

      kind4    <= kind3;
      expd4    <= expd3;
      meta4    <= meta3;
      lin4     <= lin3;
      sq4      <= sq3;
      tt4      <= tt3;
      ttt4     <= ttt_prod[FRAC_W +: FRAC_W];

      out_dens <= dens;
      out_meta <= meta4;
    end
  end

endmodule

// ----- design/fog_density_curve_generator_top.sv -----
// ----------------------------------------------------------------------------
// fog_density_curve_generator_top
// Turns one fog setup request into a 32-entry fog density table stream.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one setup request per transfer: the curve kind in
// s_tuser and the depths, color and alpha in s_tdata. The master channel
// returns the table entries in order, one transfer per entry, with m_tlast on
// entry 31. A request whose far depth is not beyond its near depth returns a
// single transfer with m_tuser and m_tlast high and all data fields zero.
// Throughput is one entry per cycle while the output is not stalled; the
// entry sequencer is the limit, and the next request is taken in the cycle
// the previous one issues its last entry.
// From a request transfer, its first entry passes the request register, the
// sequencer register, three curve stages and the output register to m_tvalid.
// When m_tready is low while m_tvalid is high the whole pipeline freezes, the
// output holds its entry, and s_tready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and drops any request in progress.
// ----------------------------------------------------------------------------
module fog_density_curve_generator_top
  import fdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // [15:0] near, [31:16] far, [46:32] fog_color, [51:47] fog_alpha
  input  logic [TDATA_W-1:0] s_tdata,
  // [1:0] curve_kind
  input  logic [KIND_W-1:0]  s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // [4:0] entry_index, [11:5] density, [15:12] band_shift,
  // [30:16] depth_offset, [51:31] color_word
  output logic [TDATA_W-1:0] m_tdata,
  // [0] rejected
  output logic               m_tuser,
  output logic               m_tlast
);

  logic              adv;
  logic              ent_valid;
  logic [KIND_W-1:0] ent_kind;
  logic [DENS_W-1:0] ent_expd;
  meta_t             ent_meta;
  logic [DENS_W-1:0] out_dens;
  meta_t             out_meta;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv = !m_tvalid || m_tready;

  fdc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_kind  (s_tuser),
    .req_near  (s_tdata[15:0]),
    .req_far   (s_tdata[31:16]),
    .req_color (s_tdata[46:32]),
    .req_alpha (s_tdata[51:47]),
    .ent_valid (ent_valid),
    .ent_kind  (ent_kind),
    .ent_expd  (ent_expd),
    .ent_meta  (ent_meta)
  );

  fdc_curve u_curve (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (ent_valid),
    .in_kind   (ent_kind),
    .in_expd   (ent_expd),
    .in_meta   (ent_meta),
    .out_valid (m_tvalid),
    .out_dens  (out_dens),
    .out_meta  (out_meta)
  );

  assign m_tdata = {4'b0, out_meta.word, out_meta.offs, out_meta.shift, out_dens,
                    out_meta.idx};
  assign m_tuser = out_meta.rej;
  assign m_tlast = out_meta.last;

endmodule

// ----- design/fdc_checker.sv -----
// ----------------------------------------------------------------------------
// fdc_checker
// Port-level checks for the fog density curve generator.
// ----------------------------------------------------------------------------
module fdc_checker
  import fdc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [TDATA_W-1:0] s_tdata,
  input logic [KIND_W-1:0]  s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser,
  input logic               m_tlast
);

  // A stalled output transfer keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // A rejection is a one-transfer answer with all data zero.
  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("rejected transfer malformed");

  // A table ends exactly on its final entry.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tlast == (m_tdata[4:0] == LAST_IDX)))
    else $error("last flag on wrong entry");

  // Entry zero always has zero density.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:0] == '0) |-> (m_tdata[11:5] == '0))
    else $error("entry zero has nonzero density");

  // Reset empties the output.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind fog_density_curve_generator_top fdc_checker u_fdc_checker (.*);
